@@ src/i2cms_pkg.sv @@
// Shared types, codes and reset values of the I2C master byte sequencer.
package i2cms_pkg;

  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 8;

  localparam logic [CfgIdxWidth-1:0] CFG_ADDRESS_MASK    = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_STATUS_MASK     = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_FIRST_DATA_MASK = 2'd2;

  localparam logic [7:0] ADDRESS_MASK_RST    = 8'd254;
  localparam logic [3:0] STATUS_MASK_RST     = 4'd15;
  localparam logic [7:0] FIRST_DATA_MASK_RST = 8'd15;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_EVENT = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START    = 4'd1,
    PH_ADDR_ACK = 4'd2,
    PH_CMD_ACK  = 4'd3,
    PH_D1_ACK   = 4'd4,
    PH_D2_ACK   = 4'd5,
    PH_RSTART   = 4'd6,
    PH_RADDR    = 4'd7,
    PH_RX1      = 4'd8,
    PH_ACK1     = 4'd9,
    PH_RX2      = 4'd10,
    PH_NACK2    = 4'd11,
    PH_STOP     = 4'd12
  } phase_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_START  = 3'd1,
    ACT_RSTART = 3'd2,
    ACT_STOP   = 3'd3,
    ACT_TX     = 3'd4,
    ACT_RCEN   = 3'd5,
    ACT_ACK    = 3'd6,
    ACT_NACK   = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    OC_OK     = 2'd0,
    OC_FAILED = 2'd1,
    OC_BUSY   = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] target_address;
    logic [7:0] command_byte;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       ack_missing;
    logic       write_collision;
    logic       start_seen;
    logic       stop_seen;
    logic [7:0] received_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] transmit_byte;
    logic       done_res;
    logic [1:0] outcome;
    logic [3:0] read_status;
    logic [7:0] read_first;
    logic [7:0] read_second;
  } result_t;

endpackage

@@ src/i2cms_in_reg.sv @@
// Input register stage: holds one accepted request or event beat.
module i2cms_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic                drain_i,
  input  i2cms_pkg::in_item_t item_i,
  output logic                valid_o,
  output i2cms_pkg::in_item_t item_o
);
  import i2cms_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (drain_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ src/i2cms_core.sv @@
// Sequencer state, configuration masks and next-action logic.
module i2cms_core (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [i2cms_pkg::CfgIdxWidth-1:0]         cfg_idx_i,
  input  logic [i2cms_pkg::CfgDataWidth-1:0]        cfg_wdata_i,
  input  logic                                      step_i,
  input  i2cms_pkg::in_item_t                       item_i,
  output i2cms_pkg::result_t                        result_o
);
  import i2cms_pkg::*;

  logic [7:0] address_mask_q;
  logic [3:0] status_mask_q;
  logic [7:0] first_data_mask_q;

  phase_e     phase_q, phase_d;
  logic       busy_q, busy_d;
  logic       first_q, first_d;
  logic       reading_q, reading_d;
  logic       failed_q, failed_d;
  logic [6:0] held_address_q, held_address_d;
  logic [7:0] held_command_q, held_command_d;
  logic [7:0] held_first_q, held_first_d;
  logic [7:0] held_second_q, held_second_d;
  logic [3:0] got_status_q, got_status_d;
  logic [7:0] got_first_q, got_first_d;
  logic [7:0] got_second_q, got_second_d;

  logic [7:0] addr_base;
  logic       bad;
  action_e    act;
  outcome_e   oc;
  logic [7:0] tx;
  logic       done;

  // Address bit 0 is cleared by the shift, so the R/W add never carries.
  assign addr_base = {held_address_q, 1'b0} & address_mask_q;
  assign bad       = item_i.ack_missing | item_i.write_collision;

  always_comb begin
    phase_d        = phase_q;
    busy_d         = busy_q;
    first_d        = first_q;
    reading_d      = reading_q;
    failed_d       = failed_q;
    held_address_d = held_address_q;
    held_command_d = held_command_q;
    held_first_d   = held_first_q;
    held_second_d  = held_second_q;
    got_status_d   = got_status_q;
    got_first_d    = got_first_q;
    got_second_d   = got_second_q;
    act            = ACT_NONE;
    oc             = OC_OK;
    tx             = 8'd0;
    done           = 1'b0;

    if (item_i.func == FUNC_WRITE || item_i.func == FUNC_READ) begin
      if (busy_q) begin
        done = 1'b1;
        oc   = OC_BUSY;
      end else if (!first_q && (item_i.start_seen || !item_i.stop_seen)) begin
        done = 1'b1;
        oc   = OC_FAILED;
      end else begin
        first_d        = 1'b0;
        busy_d         = 1'b1;
        failed_d       = 1'b0;
        reading_d      = (item_i.func == FUNC_READ);
        held_address_d = item_i.target_address;
        held_command_d = item_i.command_byte;
        held_first_d   = item_i.first_byte;
        held_second_d  = item_i.second_byte;
        act            = ACT_START;
        phase_d        = PH_START;
      end
    end else if (item_i.func == FUNC_EVENT && busy_q) begin
      case (phase_q)
        PH_START: begin
          if (item_i.start_seen && !item_i.stop_seen) begin
            act = ACT_TX; tx = addr_base; phase_d = PH_ADDR_ACK;
          end else begin
            act = ACT_STOP; failed_d = 1'b1; phase_d = PH_STOP;
          end
        end
        PH_ADDR_ACK: begin
          if (!bad) begin
            act = ACT_TX; tx = held_command_q; phase_d = PH_CMD_ACK;
          end else begin
            act = ACT_STOP; failed_d = 1'b1; phase_d = PH_STOP;
          end
        end
        PH_CMD_ACK: begin
          if (bad) begin
            act = ACT_STOP; failed_d = 1'b1; phase_d = PH_STOP;
          end else if (reading_q) begin
            act = ACT_RSTART; phase_d = PH_RSTART;
          end else begin
            act = ACT_TX; tx = held_first_q; phase_d = PH_D1_ACK;
          end
        end
        PH_D1_ACK: begin
          if (!bad) begin
            act = ACT_TX; tx = held_second_q; phase_d = PH_D2_ACK;
          end else begin
            act = ACT_STOP; failed_d = 1'b1; phase_d = PH_STOP;
          end
        end
        PH_D2_ACK: begin
          if (bad) begin
            failed_d = 1'b1;
          end
          act = ACT_STOP; phase_d = PH_STOP;
        end
        PH_RSTART: begin
          act = ACT_TX; tx = addr_base + 8'd1; phase_d = PH_RADDR;
        end
        PH_RADDR: begin
          act = ACT_RCEN; phase_d = PH_RX1;
        end
        PH_RX1: begin
          got_status_d = item_i.received_byte[7:4] & status_mask_q;
          got_first_d  = item_i.received_byte & first_data_mask_q;
          act = ACT_ACK; phase_d = PH_ACK1;
        end
        PH_ACK1: begin
          act = ACT_RCEN; phase_d = PH_RX2;
        end
        PH_RX2: begin
          got_second_d = item_i.received_byte;
          act = ACT_NACK; phase_d = PH_NACK2;
        end
        PH_NACK2: begin
          act = ACT_STOP; phase_d = PH_STOP;
        end
        PH_STOP: begin
          done    = 1'b1;
          oc      = failed_q ? OC_FAILED : OC_OK;
          phase_d = PH_IDLE;
          busy_d  = 1'b0;
        end
        default: begin
          done    = 1'b1;
          oc      = OC_FAILED;
          phase_d = PH_IDLE;
          busy_d  = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    result_o.bus_action    = act;
    result_o.transmit_byte = tx;
    result_o.done_res      = done;
    result_o.outcome       = oc;
    result_o.read_status   = got_status_d;
    result_o.read_first    = got_first_d;
    result_o.read_second   = got_second_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_mask_q    <= ADDRESS_MASK_RST;
      status_mask_q     <= STATUS_MASK_RST;
      first_data_mask_q <= FIRST_DATA_MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ADDRESS_MASK:    address_mask_q    <= cfg_wdata_i;
        CFG_STATUS_MASK:     status_mask_q     <= cfg_wdata_i[3:0];
        CFG_FIRST_DATA_MASK: first_data_mask_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      busy_q         <= 1'b0;
      first_q        <= 1'b1;
      reading_q      <= 1'b0;
      failed_q       <= 1'b0;
      held_address_q <= '0;
      held_command_q <= '0;
      held_first_q   <= '0;
      held_second_q  <= '0;
      got_status_q   <= '0;
      got_first_q    <= '0;
      got_second_q   <= '0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      busy_q         <= busy_d;
      first_q        <= first_d;
      reading_q      <= reading_d;
      failed_q       <= failed_d;
      held_address_q <= held_address_d;
      held_command_q <= held_command_d;
      held_first_q   <= held_first_d;
      held_second_q  <= held_second_d;
      got_status_q   <= got_status_d;
      got_first_q    <= got_first_d;
      got_second_q   <= got_second_d;
    end
  end

endmodule

@@ src/i2cms_out_reg.sv @@
// Result register: holds one result beat until the receiver takes it.
module i2cms_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               take_i,
  input  i2cms_pkg::result_t result_i,
  output logic               valid_o,
  output i2cms_pkg::result_t result_o
);
  import i2cms_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

@@ src/i2c_master_transaction_sequencer_unit.sv @@
// Top level of the I2C master byte sequencer.
//
// Input channel (in_valid_i / in_ready_o): one beat is a write request, a read
// request, a completion event from the byte engine or a no-op, selected by func_i.
// Output channel (out_valid_o / out_ready_i): exactly one result beat per input
// beat, in order: the next bus action, the byte to transmit, done and outcome,
// and the read-back status and data.
// Configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i): index 0 address mask,
// 1 status mask, 2 first data mask; a write lands at the clock edge, no wait.
// Write only while no beat is in flight.
//
// An accepted beat is held in the input register; its result is registered in the result register.
// Throughput: one beat per cycle while the receiver does not stall, set by the
// single input register feeding the sequencer logic and the result register.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more beat; after that in_ready_o drops.
// Reset clears both registers' valid flags, sets the sequencer idle with the
// first-transfer flag set, and restores the configuration reset masks.
module i2c_master_transaction_sequencer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [i2cms_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [i2cms_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         func_i,
  input  logic [6:0]                         target_address_i,
  input  logic [7:0]                         command_byte_i,
  input  logic [7:0]                         first_byte_i,
  input  logic [7:0]                         second_byte_i,
  input  logic                               ack_missing_i,
  input  logic                               write_collision_i,
  input  logic                               start_seen_i,
  input  logic                               stop_seen_i,
  input  logic [7:0]                         received_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [2:0]                         bus_action_o,
  output logic [7:0]                         transmit_byte_o,
  output logic                               done_res_o,
  output logic [1:0]                         outcome_o,
  output logic [3:0]                         read_status_o,
  output logic [7:0]                         read_first_o,
  output logic [7:0]                         read_second_o
);
  import i2cms_pkg::*;

  in_item_t in_item, s1_item;
  result_t  core_result, out_result;
  logic     s1_valid, step, in_fire;

  always_comb begin
    in_item.func            = func_i;
    in_item.target_address  = target_address_i;
    in_item.command_byte    = command_byte_i;
    in_item.first_byte      = first_byte_i;
    in_item.second_byte     = second_byte_i;
    in_item.ack_missing     = ack_missing_i;
    in_item.write_collision = write_collision_i;
    in_item.start_seen      = start_seen_i;
    in_item.stop_seen       = stop_seen_i;
    in_item.received_byte   = received_byte_i;
  end

  // Advance the held beat whenever the result register is free or draining.
  assign step       = s1_valid && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid || step;
  assign in_fire    = in_valid_i && in_ready_o;

  i2cms_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_fire),
    .drain_i (step),
    .item_i  (in_item),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  i2cms_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (s1_item),
    .result_o    (core_result)
  );

  i2cms_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step),
    .take_i   (out_ready_i),
    .result_i (core_result),
    .valid_o  (out_valid_o),
    .result_o (out_result)
  );

  assign bus_action_o    = out_result.bus_action;
  assign transmit_byte_o = out_result.transmit_byte;
  assign done_res_o      = out_result.done_res;
  assign outcome_o       = out_result.outcome;
  assign read_status_o   = out_result.read_status;
  assign read_first_o    = out_result.read_first;
  assign read_second_o   = out_result.read_second;

endmodule

@@ src/i2cms_checker.sv @@
// Port-level checks of the sequencer result channel, bound to the top level.
module i2cms_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] bus_action_o,
  input logic [7:0] transmit_byte_o,
  input logic       done_res_o,
  input logic [1:0] outcome_o
);
  import i2cms_pkg::*;

  // A stalled result beat holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bus_action_o)
      && $stable(transmit_byte_o) && $stable(done_res_o))
    else $error("result beat changed under stall");

  a_done_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> bus_action_o == ACT_NONE)
    else $error("bus action issued together with done");

  a_outcome_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o != OC_OK |-> done_res_o)
    else $error("outcome reported without done");

  a_tx_byte_only_on_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bus_action_o != ACT_TX |-> transmit_byte_o == 8'd0)
    else $error("transmit byte set without transmit action");

endmodule

bind i2c_master_transaction_sequencer_unit i2cms_checker u_i2cms_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .bus_action_o    (bus_action_o),
  .transmit_byte_o (transmit_byte_o),
  .done_res_o      (done_res_o),
  .outcome_o       (outcome_o)
);
